// File: hdl/rlfc_pkg.sv
`default_nettype none

package rlfc_pkg;

  // Number of clamp flag bits that are watched.
  localparam int unsigned FLAG_BITS = 10;

  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned TIMER_W = 31;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned CFG_W   = 31;

  // Filter level of 1.0 in Q1.16 and the hysteresis thresholds.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 17'd65536;
  localparam logic [LEVEL_W-1:0] SET_LEVEL   = 17'd41425;
  localparam logic [LEVEL_W-1:0] CLEAR_LEVEL = 17'd24111;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TICK_TIME   = 2'd0,
    CFG_FILTER_COEF = 2'd1,
    CFG_LIMIT_TIME  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam logic [TICK_W-1:0]  TICK_TIME_RST   = 16'd200;
  localparam logic [COEF_W-1:0]  FILTER_COEF_RST = 16'd655;
  localparam logic [TIMER_W-1:0] LIMIT_TIME_RST  = 31'd100000;

  typedef struct packed {
    logic [15:0] clamp_flags;
    logic        regulator_enabled;
  } in_item_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0] masked_flags;
    logic                 any_clamp;
    logic [LEVEL_W-1:0]   filter_out;
    logic                 in_limit;
    logic                 fault;
    logic [FLAG_BITS-1:0] history;
    logic [TIMER_W-1:0]   timer_out;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]  tick_time;
    logic [COEF_W-1:0]  filter_coef;
    logic [TIMER_W-1:0] limit_time;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/rlfc_cfg_regs.sv
`default_nettype none

module rlfc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rlfc_pkg::CFG_W-1:0]  cfg_wdata,
  output rlfc_pkg::cfg_t                   cfg
);

  rlfc_pkg::cfg_t cfg_r;
  rlfc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (rlfc_pkg::cfg_index_t'(cfg_index))
        rlfc_pkg::CFG_TICK_TIME:   cfg_nxt.tick_time   = cfg_wdata[rlfc_pkg::TICK_W-1:0];
        rlfc_pkg::CFG_FILTER_COEF: cfg_nxt.filter_coef = cfg_wdata[rlfc_pkg::COEF_W-1:0];
        rlfc_pkg::CFG_LIMIT_TIME:  cfg_nxt.limit_time  = cfg_wdata[rlfc_pkg::TIMER_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_time   <= rlfc_pkg::TICK_TIME_RST;
      cfg_r.filter_coef <= rlfc_pkg::FILTER_COEF_RST;
      cfg_r.limit_time  <= rlfc_pkg::LIMIT_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/rlfc_filter.sv
`default_nettype none

module rlfc_filter (
  input  wire logic [rlfc_pkg::LEVEL_W-1:0] level,
  input  wire logic                         limit_state,
  input  wire logic                         any_clamp,
  input  wire logic [rlfc_pkg::COEF_W-1:0]  coef,
  output logic      [rlfc_pkg::LEVEL_W-1:0] level_nxt,
  output logic                              limit_nxt
);

  logic [16:0] operand;
  logic [32:0] prod;
  logic [33:0] prod_rnd;
  logic [17:0] down;
  logic [17:0] up_sum;

  // One shared multiplier: toward 1.0 the distance is scaled, toward 0 the level.
  assign operand  = any_clamp ? (rlfc_pkg::LEVEL_ONE - level) : level;
  assign prod     = 33'(coef) * 33'(operand);
  // The down step is rounded up so that the subtraction floors toward minus infinity.
  assign prod_rnd = {1'b0, prod} + 34'd65535;
  assign down     = prod_rnd[33:16];
  assign up_sum   = {1'b0, level} + {1'b0, prod[32:16]};

  always_comb begin
    if (any_clamp) begin
      if (up_sum > {1'b0, rlfc_pkg::LEVEL_ONE}) begin
        level_nxt = rlfc_pkg::LEVEL_ONE;
      end else begin
        level_nxt = up_sum[16:0];
      end
    end else begin
      if (down > {1'b0, level}) begin
        level_nxt = '0;
      end else begin
        level_nxt = level - down[16:0];
      end
    end
  end

  always_comb begin
    if (level_nxt >= rlfc_pkg::SET_LEVEL) begin
      limit_nxt = 1'b1;
    end else if (level_nxt <= rlfc_pkg::CLEAR_LEVEL) begin
      limit_nxt = 1'b0;
    end else begin
      limit_nxt = limit_state;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rlfc_timer.sv
`default_nettype none

module rlfc_timer (
  input  wire logic [rlfc_pkg::TIMER_W-1:0] timer,
  input  wire logic                         in_limit,
  input  wire logic [rlfc_pkg::TICK_W-1:0]  tick_time,
  input  wire logic [rlfc_pkg::TIMER_W-1:0] limit_time,
  output logic      [rlfc_pkg::TIMER_W-1:0] timer_nxt,
  output logic                              fault
);

  logic [31:0] timer_ext;
  logic [31:0] tick_ext;
  logic [31:0] count;

  assign timer_ext = {1'b0, timer};
  assign tick_ext  = 32'(tick_time);

  // Count up while in limit, otherwise down to a floor of zero.
  always_comb begin
    if (in_limit) begin
      count = timer_ext + tick_ext;
    end else if (timer_ext > tick_ext) begin
      count = timer_ext - tick_ext;
    end else begin
      count = '0;
    end
  end

  assign fault     = count >= {1'b0, limit_time};
  assign timer_nxt = fault ? limit_time : count[rlfc_pkg::TIMER_W-1:0];

endmodule

`default_nettype wire

// File: hdl/regulator_limit_fault_checker.sv
`default_nettype none

// Regulator limit fault checker. Each input transfer is one task tick carrying the
// regulator clamp flags and an enable bit; each tick produces exactly one result
// transfer. The low ten flags feed a first-order low-pass filter (Q1.16), a hysteresis
// on the filter level gives the in-limit alarm, a timer counts time spent in limit,
// and the fault bit is raised when that timer reaches limit_time. A tick accepted by
// the block sits in the input register, and its result is written into the output
// register as soon as that register is free. The block sustains one tick per clock
// cycle while the receiver does not stall, because the whole update for a tick is
// done combinationally between the input register and the state registers: a 16 by
// 17 bit multiply with its add and clamp, the two hysteresis compares, and the 32-bit
// timer add or subtract with its limit compare. The input stalls only while a result
// waits on a stalled receiver and the input register is full. Configuration writes
// take effect on the next clock edge and should be made while no tick is in flight.
module regulator_limit_fault_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rlfc_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rlfc_pkg::out_item_t              out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [rlfc_pkg::CFG_W-1:0]  cfg_wdata
);

  rlfc_pkg::cfg_t cfg;

  // Input register stage.
  logic                s1_valid_r;
  rlfc_pkg::in_item_t  s1_data_r;

  // Output register stage.
  logic                out_valid_r;
  rlfc_pkg::out_item_t out_data_r;
  rlfc_pkg::out_item_t out_data_nxt;

  // Checker state carried from tick to tick.
  logic [rlfc_pkg::LEVEL_W-1:0]   level_r;
  logic [rlfc_pkg::LEVEL_W-1:0]   level_nxt;
  logic                           limit_r;
  logic                           limit_nxt;
  logic [rlfc_pkg::TIMER_W-1:0]   timer_r;
  logic [rlfc_pkg::TIMER_W-1:0]   timer_nxt;
  logic [rlfc_pkg::FLAG_BITS-1:0] history_r;
  logic [rlfc_pkg::FLAG_BITS-1:0] history_nxt;

  logic [rlfc_pkg::FLAG_BITS-1:0] flags;
  logic                           any_clamp;
  logic                           fault;
  logic                           out_free;
  logic                           s1_move;
  logic                           in_take;

  rlfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  // The input register frees up in the same cycle its tick moves on.
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign flags     = s1_data_r.clamp_flags[rlfc_pkg::FLAG_BITS-1:0];
  assign any_clamp = |flags;

  rlfc_filter u_filter (
    .level       (level_r),
    .limit_state (limit_r),
    .any_clamp   (any_clamp),
    .coef        (cfg.filter_coef),
    .level_nxt   (level_nxt),
    .limit_nxt   (limit_nxt)
  );

  rlfc_timer u_timer (
    .timer      (timer_r),
    .in_limit   (limit_nxt),
    .tick_time  (cfg.tick_time),
    .limit_time (cfg.limit_time),
    .timer_nxt  (timer_nxt),
    .fault      (fault)
  );

  // The history records flags during alarm or fault, only while the regulator is enabled.
  assign history_nxt = ((limit_nxt || fault) && s1_data_r.regulator_enabled)
                       ? (history_r | flags) : history_r;

  always_comb begin
    out_data_nxt.masked_flags = flags;
    out_data_nxt.any_clamp    = any_clamp;
    out_data_nxt.filter_out   = level_nxt;
    out_data_nxt.in_limit     = limit_nxt;
    out_data_nxt.fault        = fault;
    out_data_nxt.history      = history_nxt;
    out_data_nxt.timer_out    = timer_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      level_r     <= '0;
      limit_r     <= 1'b0;
      timer_r     <= '0;
      history_r   <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        level_r     <= level_nxt;
        limit_r     <= limit_nxt;
        timer_r     <= timer_nxt;
        history_r   <= history_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/rlfc_checker.sv
`default_nettype none

module rlfc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire rlfc_pkg::out_item_t         out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input is only held off while a result waits on a stalled receiver.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // The any-clamp bit agrees with the masked flags.
  a_any_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.any_clamp == (out_data.masked_flags != '0)))
    else $error("any_clamp disagrees with masked_flags");

  // The filter level never goes past 1.0.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.filter_out <= rlfc_pkg::LEVEL_ONE))
    else $error("filter level out of range");

  // Hysteresis: in limit at or above SET_LEVEL, out of it at or below CLEAR_LEVEL.
  a_hysteresis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.filter_out >= rlfc_pkg::SET_LEVEL) ? out_data.in_limit :
                   ((out_data.filter_out <= rlfc_pkg::CLEAR_LEVEL) ?
                    !out_data.in_limit : 1'b1)))
    else $error("in_limit disagrees with filter level");

endmodule

bind regulator_limit_fault_checker rlfc_checker u_rlfc_checker (.*);

`default_nettype wire

// File: tb/sv/tb_regulator_limit_fault_checker.sv
`timescale 1ns / 100ps

module tb_regulator_limit_fault_checker;

  // Run shape. Every tick yields exactly one result, and the block holds ticks only
  // in its two registers, so the watchdog must only outlast the receiver hold-off.
  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 191;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 10;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int REPORT_LIMIT    = 10;

  // The ledger mirrors the checker: it keeps its own copy of the registers and of
  // the filter, hysteresis, timer and history state. It turns every accepted tick
  // into the result the block must produce, and holds those results in order.
  class limit_tick_ledger;
    logic [rlfc_pkg::TICK_W-1:0]    tick_time;
    logic [rlfc_pkg::COEF_W-1:0]    filter_coef;
    logic [rlfc_pkg::TIMER_W-1:0]   limit_time;
    logic [rlfc_pkg::LEVEL_W-1:0]   level;
    logic                           in_limit;
    logic [31:0]                    timer;
    logic [rlfc_pkg::FLAG_BITS-1:0] history;
    rlfc_pkg::out_item_t            expected_ticks[$];
    int unsigned                    ticks_noted;
    int unsigned                    results_checked;
    int unsigned                    mismatches;
    int unsigned                    faults_seen;
    int unsigned                    limit_entries;

    function new();
      tick_time       = rlfc_pkg::TICK_TIME_RST;
      filter_coef     = rlfc_pkg::FILTER_COEF_RST;
      limit_time      = rlfc_pkg::LIMIT_TIME_RST;
      level           = '0;
      in_limit        = 1'b0;
      timer           = '0;
      history         = '0;
      ticks_noted     = 0;
      results_checked = 0;
      mismatches      = 0;
      faults_seen     = 0;
      limit_entries   = 0;
    endfunction

    function void write_reg(rlfc_pkg::cfg_index_t idx, logic [rlfc_pkg::CFG_W-1:0] value);
      case (idx)
        rlfc_pkg::CFG_TICK_TIME:   tick_time   = value[rlfc_pkg::TICK_W-1:0];
        rlfc_pkg::CFG_FILTER_COEF: filter_coef = value[rlfc_pkg::COEF_W-1:0];
        rlfc_pkg::CFG_LIMIT_TIME:  limit_time  = value[rlfc_pkg::TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function rlfc_pkg::out_item_t predict_tick(rlfc_pkg::in_item_t tick);
      rlfc_pkg::out_item_t            res;
      logic [rlfc_pkg::FLAG_BITS-1:0] flags;
      logic [47:0]                    prod;
      logic [47:0]                    down;
      logic [32:0]                    t;
      logic                           was_in_limit;
      flags = tick.clamp_flags[rlfc_pkg::FLAG_BITS-1:0];
      if (level > rlfc_pkg::LEVEL_ONE) level = rlfc_pkg::LEVEL_ONE;
      // The step toward the target is floored, so a fall rounds its size up.
      if (|flags) begin
        prod  = 48'(filter_coef) * 48'(rlfc_pkg::LEVEL_ONE - level);
        level = level + rlfc_pkg::LEVEL_W'(prod >> 16);
      end else begin
        prod  = 48'(filter_coef) * 48'(level);
        down  = (prod + 48'd65535) >> 16;
        level = (down > 48'(level)) ? '0 : level - rlfc_pkg::LEVEL_W'(down);
      end
      if (level > rlfc_pkg::LEVEL_ONE) level = rlfc_pkg::LEVEL_ONE;

      was_in_limit = in_limit;
      if (level >= rlfc_pkg::SET_LEVEL) in_limit = 1'b1;
      else if (level <= rlfc_pkg::CLEAR_LEVEL) in_limit = 1'b0;
      if (in_limit && !was_in_limit) limit_entries++;

      t = {1'b0, timer};
      if (in_limit) begin
        t = t + 33'(tick_time);
        if (tick.regulator_enabled) history = history | flags;
      end else begin
        t = (t > 33'(tick_time)) ? t - 33'(tick_time) : '0;
      end
      res.fault = 1'b0;
      if (t >= 33'(limit_time)) begin
        res.fault = 1'b1;
        t = 33'(limit_time);
        if (tick.regulator_enabled) history = history | flags;
        faults_seen++;
      end
      timer = t[31:0];

      res.masked_flags = flags;
      res.any_clamp    = |flags;
      res.filter_out   = level;
      res.in_limit     = in_limit;
      res.history      = history;
      res.timer_out    = timer[rlfc_pkg::TIMER_W-1:0];
      return res;
    endfunction

    function void note_tick(rlfc_pkg::in_item_t tick);
      expected_ticks.push_back(predict_tick(tick));
      ticks_noted++;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result %0d, %s: expected %0d, got %0d", results_checked, name,
                   exp_v, got_v);
      end
    endfunction

    function void check_result(rlfc_pkg::out_item_t got);
      rlfc_pkg::out_item_t exp_r;
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Result transfer with no tick outstanding: %h", got);
        return;
      end
      exp_r = expected_ticks.pop_front();
      check_field("masked_flags", 32'(exp_r.masked_flags), 32'(got.masked_flags));
      check_field("any_clamp", 32'(exp_r.any_clamp), 32'(got.any_clamp));
      check_field("filter_out", 32'(exp_r.filter_out), 32'(got.filter_out));
      check_field("in_limit", 32'(exp_r.in_limit), 32'(got.in_limit));
      check_field("fault", 32'(exp_r.fault), 32'(got.fault));
      check_field("history", 32'(exp_r.history), 32'(got.history));
      check_field("timer_out", 32'(exp_r.timer_out), 32'(got.timer_out));
      results_checked++;
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  rlfc_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  rlfc_pkg::out_item_t           out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [1:0]                    cfg_index = rlfc_pkg::CFG_TICK_TIME;
  logic [rlfc_pkg::CFG_W-1:0]    cfg_wdata = '0;

  limit_tick_ledger ledger = new();

  // Sender state: the position in the current clamp run and in the current burst.
  bit clamping   = 1'b0;
  int run_left   = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  regulator_limit_fault_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Offer one tick at the falling edge and hold it until the block takes it. The
  // ledger only learns of the tick once the transfer has really happened. Valid is
  // left high so that back-to-back ticks never drop it between transfers.
  task automatic send_tick(rlfc_pkg::in_item_t tick);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = tick;
    do @(posedge clk); while (in_stall);
    ledger.note_tick(tick);
  endtask

  // Random ticks arrive in bursts. About a third of the bursts follow the previous
  // one with no gap at all, so long unbroken stretches also occur.
  task automatic offer_tick(rlfc_pkg::in_item_t tick);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_tick(tick);
  endtask

  // The sender stops and waits until every result has come back. Every tick has a
  // result, so an empty ledger means the block is idle; the extra wait covers the
  // two-stage pipeline before the registers are touched.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(rlfc_pkg::cfg_index_t idx, logic [rlfc_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    ledger.write_reg(idx, value);
  endtask

  task automatic set_config(logic [rlfc_pkg::TICK_W-1:0] tick_val,
                            logic [rlfc_pkg::COEF_W-1:0] coef_val,
                            logic [rlfc_pkg::TIMER_W-1:0] limit_val);
    cfg_write(rlfc_pkg::CFG_TICK_TIME, rlfc_pkg::CFG_W'(tick_val));
    cfg_write(rlfc_pkg::CFG_FILTER_COEF, rlfc_pkg::CFG_W'(coef_val));
    cfg_write(rlfc_pkg::CFG_LIMIT_TIME, rlfc_pkg::CFG_W'(limit_val));
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Random ticks follow clamp runs of random length, so the filter climbs through
  // the set threshold and falls back through the clear threshold again and again.
  // A share of the ticks is noise: flags only in the ignored upper bits, or a wild
  // word that breaks the current run.
  function automatic rlfc_pkg::in_item_t next_random_tick();
    rlfc_pkg::in_item_t tick;
    if (run_left == 0) begin
      clamping = ~clamping;
      run_left = $urandom_range(1, 60);
    end
    run_left--;
    case ($urandom_range(0, 9))
      0: tick.clamp_flags = 16'($urandom) & 16'hFC00;
      1: tick.clamp_flags = 16'($urandom);
      default: begin
        if (clamping)
          tick.clamp_flags = ($urandom_range(0, 1) == 0) ? 16'(1 << $urandom_range(0, 9))
                                                        : (16'($urandom) | 16'h0001);
        else
          tick.clamp_flags = ($urandom_range(0, 1) == 0) ? 16'h0000
                                                        : (16'($urandom) & 16'hFC00);
      end
    endcase
    tick.regulator_enabled = ($urandom_range(0, 7) != 0);
    return tick;
  endfunction

  // Results are checked at the rising edge, on the values that held just before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_result(out_data);
  end

  // The watchdog ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls on a pattern of its own, drawn anew at random for each stretch:
  // no stall, light stall, heavy stall, or a regular periodic stall. Twice in the run
  // it holds off for a long stretch while the sender keeps offering ticks, so the
  // pipeline fills up and the block must stall its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int cycle_no;
    bit held_early;
    bit held_late;
    mode       = 0;
    mode_left  = 0;
    cycle_no   = 0;
    held_early = 1'b0;
    held_late  = 1'b0;
    forever begin
      @(negedge clk);
      cycle_no++;
      if ((!held_early && ledger.results_checked >= 300) ||
          (!held_late && ledger.results_checked >= 1000)) begin
        if (held_early) held_late = 1'b1;
        held_early = 1'b1;
        out_stall  = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = (cycle_no % 3 == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int p;
    int i;
    int errors;
    logic [rlfc_pkg::TICK_W-1:0]  tick_val;
    logic [rlfc_pkg::TIMER_W-1:0] limit_val;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: extremes of the flag word, flags only in the ignored upper
    // bits, single flags at both ends of the mask, and both enable values.
    send_tick(rlfc_pkg::in_item_t'{16'h0000, 1'b0});
    send_tick(rlfc_pkg::in_item_t'{16'hFFFF, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'hFC00, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h03FF, 1'b0});
    send_tick(rlfc_pkg::in_item_t'{16'h0001, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h0200, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'hAAAA, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h5555, 1'b0});
    wait_idle();

    // A limit of zero faults on every tick even out of limit; with a zero tick
    // time the timer stays put and with a zero coefficient the filter is frozen.
    // The fault alone lets enabled ticks into the history.
    set_config('0, '0, '0);
    send_tick(rlfc_pkg::in_item_t'{16'hFFFF, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h0000, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h0155, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h02AA, 1'b0});
    wait_idle();

    // Fastest filter and largest tick against the largest limit: the level jumps
    // into limit on the first clamp, the timer climbs, then drops on release.
    set_config('1, '1, '1);
    for (i = 0; i < 5; i++) send_tick(rlfc_pkg::in_item_t'{16'h03FF, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h0000, 1'b1});
    wait_idle();

    // The limit is lowered under the running timer: the next tick must clamp the
    // timer to the new limit and raise the fault.
    set_config(16'd1, '1, 31'd1000);
    send_tick(rlfc_pkg::in_item_t'{16'h0300, 1'b1});
    send_tick(rlfc_pkg::in_item_t'{16'h03FF, 1'b0});
    send_tick(rlfc_pkg::in_item_t'{16'h0001, 1'b1});
    wait_idle();

    // Random phases, each with its own register setting, extremes among them.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          tick_val = rlfc_pkg::TICK_W'($urandom_range(100, 2000));
          set_config(tick_val, rlfc_pkg::COEF_W'($urandom_range(2000, 20000)),
                     rlfc_pkg::TIMER_W'(tick_val * $urandom_range(3, 30)));
          // The spare index must not disturb any register.
          cfg_write(rlfc_pkg::CFG_UNUSED, rlfc_pkg::CFG_W'($urandom));
          @(negedge clk);
          cfg_wr_en = 1'b0;
        end
        1: set_config(16'd1, '1, rlfc_pkg::TIMER_W'($urandom_range(0, 50)));
        2: set_config('1, rlfc_pkg::COEF_W'($urandom_range(1000, 65535)), '1);
        3: begin
          // Lower the limit under whatever the previous phase left on the timer.
          limit_val = (ledger.timer > 32'd1) ? rlfc_pkg::TIMER_W'(ledger.timer >> 1)
                                             : rlfc_pkg::TIMER_W'($urandom_range(0, 1000));
          set_config(rlfc_pkg::TICK_W'($urandom_range(1, 65535)),
                     rlfc_pkg::COEF_W'($urandom_range(1000, 30000)), limit_val);
        end
        4: set_config(rlfc_pkg::TICK_W'($urandom), rlfc_pkg::COEF_W'($urandom),
                      rlfc_pkg::TIMER_W'($urandom) >> $urandom_range(0, 30));
        5: set_config(rlfc_pkg::TICK_W'($urandom_range(1, 500)),
                      rlfc_pkg::COEF_W'($urandom_range(5000, 40000)), '0);
        6: set_config(rlfc_pkg::TICK_TIME_RST,
                      rlfc_pkg::COEF_W'($urandom_range(3000, 12000)),
                      rlfc_pkg::TIMER_W'($urandom_range(1000, 20000)));
        default: begin
          tick_val = rlfc_pkg::TICK_W'($urandom_range(1, 3000));
          set_config(tick_val, rlfc_pkg::COEF_W'($urandom),
                     rlfc_pkg::TIMER_W'(tick_val * $urandom_range(1, 10)));
        end
      endcase
      for (i = 0; i < TICKS_PER_PHASE; i++) offer_tick(next_random_tick());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    errors = ledger.mismatches + ledger.pending();
    if (ledger.pending() != 0)
      $display("%0d ticks never produced a result", ledger.pending());
    $display("Checked %0d results from %0d ticks over %0d register settings.",
             ledger.results_checked, ledger.ticks_noted, RANDOM_PHASES + 4);
    $display("The alarm was entered %0d times and the fault raised on %0d ticks.",
             ledger.limit_entries, ledger.faults_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
